### rtl/cfp_pkg.sv
package cfp_pkg;

   // Frame delimiters.
   localparam logic [7:0] HDR_A = 8'hFE;
   localparam logic [7:0] HDR_B = 8'hFF;
   localparam logic [7:0] FTR_A = 8'h0A;
   localparam logic [7:0] FTR_B = 8'h0D;

   // Defaults for the configuration register and the payload size.
   localparam logic [7:0] CMD_ID_RESET  = 8'h01;
   localparam int         PAYLOAD_BYTES = 8;

   // Result of one byte step, handed from the recognizer to the output stage.
   typedef struct packed {
      logic        valid;
      logic [31:0] first_word;
      logic [31:0] second_word;
   } result_type;

endpackage

### rtl/cfp_frame_fsm.sv
module cfp_frame_fsm #(
   parameter int PAYLOAD_BYTES = cfp_pkg::PAYLOAD_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           command_id,
   output cfp_pkg::result_type  result
);

   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   typedef enum logic [7:0] {
      HUNT_A   = 8'b0000_0001,
      HUNT_B   = 8'b0000_0010,
      CMD_ID   = 8'b0000_0100,
      LENGTH   = 8'b0000_1000,
      PAYLOAD  = 8'b0001_0000,
      CHECKSUM = 8'b0010_0000,
      FOOTER_A = 8'b0100_0000,
      FOOTER_B = 8'b1000_0000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       store_ff [PAYLOAD_BYTES];
   logic [63:0]      packed_payload;

   // Next phase, byte counter and running checksum for the byte at hand.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      unique case (phase_ff)
         HUNT_A: begin
            if (rx_byte == cfp_pkg::HDR_A) phase_in = HUNT_B;
         end
         HUNT_B: begin
            phase_in = (rx_byte == cfp_pkg::HDR_B) ? CMD_ID : HUNT_A;
         end
         CMD_ID: begin
            phase_in = (rx_byte == command_id) ? LENGTH : HUNT_A;
         end
         LENGTH: begin
            if (rx_byte == 8'(PAYLOAD_BYTES)) begin
               count_in = '0;
               sum_in   = '0;
               phase_in = PAYLOAD;
            end else begin
               phase_in = HUNT_A;
            end
         end
         PAYLOAD: begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + rx_byte;
            if (count_in == CNT_W'(PAYLOAD_BYTES)) phase_in = CHECKSUM;
         end
         CHECKSUM: begin
            phase_in = (rx_byte == sum_ff) ? FOOTER_A : HUNT_A;
         end
         FOOTER_A: begin
            phase_in = (rx_byte == cfp_pkg::FTR_A) ? FOOTER_B : HUNT_A;
         end
         FOOTER_B: begin
            phase_in = HUNT_A;
         end
         default: begin
            phase_in = HUNT_A;
         end
      endcase
   end

   // Control state of the recognizer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT_A;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // Payload bytes land at the position the counter points to.
   always_ff @(posedge clock) begin
      if (step && phase_ff == PAYLOAD) begin
         store_ff[count_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   // Byte positions beyond the payload size read as zero.
   for (genvar k = 0; k < 8; k++) begin : g_pack
      if (k < PAYLOAD_BYTES) begin : g_used
         assign packed_payload[k*8 +: 8] = store_ff[k];
      end else begin : g_unused
         assign packed_payload[k*8 +: 8] = 8'h00;
      end
   end

   // A result comes with a correct second footer byte.
   always_comb begin
      result.valid       = (phase_ff == FOOTER_B) && (rx_byte == cfp_pkg::FTR_B);
      result.first_word  = packed_payload[31:0];
      result.second_word = packed_payload[63:32];
   end

endmodule

### rtl/cfp_rsp_stage.sv
module cfp_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cfp_pkg::result_type  result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_first_word,
   output logic [31:0]          rsp_second_word,
   output logic                 free
);

   logic        valid_ff;
   logic [31:0] first_ff;
   logic [31:0] second_ff;

   // The stage can take a new result when empty or when its transaction completes now.
   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         first_ff  <= result.first_word;
         second_ff <= result.second_word;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_first_word  = first_ff;
   assign rsp_second_word = second_ff;

endmodule

### rtl/command_frame_parser_core.sv
// A result reaches rsp_valid from the footer byte's transaction via the input register,
// then the result register. Throughput: one byte per cycle through the recognizer step
// between the two, except while a byte that completes a frame waits for a full output.
// Reset (synchronous, active high) returns the recognizer to header hunting, empties
// both registers and sets command_id to 1; payload bytes are undefined until written.
module command_frame_parser_core #(
   parameter int PAYLOAD_BYTES = cfp_pkg::PAYLOAD_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_first_word,
   output logic [31:0] rsp_second_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic [7:0]          cmd_id_ff;
   logic                advance;
   logic                out_free;
   cfp_pkg::result_type result;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_id_ff <= cfp_pkg::CMD_ID_RESET;
      end else if (csr_valid) begin
         cmd_id_ff <= csr_data;
      end
   end

   // The held byte moves on unless it completes a frame while the output is full.
   assign advance   = in_valid_ff && (!result.valid || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   cfp_frame_fsm #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .command_id (cmd_id_ff),
      .result     (result)
   );

   cfp_rsp_stage u_rsp (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && result.valid),
      .result          (result),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_first_word  (rsp_first_word),
      .rsp_second_word (rsp_second_word),
      .free            (out_free)
   );

endmodule

### verif/command_frame_parser_core_tb.sv
`timescale 1ns / 100ps

module command_frame_parser_core_tb;

   localparam int PAYLOAD_LEN  = cfp_pkg::PAYLOAD_BYTES;
   localparam int FRAME_LEN    = PAYLOAD_LEN + 7;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 33;
   localparam int HOLD_CYCLES  = 400;

   // Recognizer phases, in the order a well-formed frame walks through them.
   typedef enum logic [2:0] {
      HUNT_HDR_A,
      HUNT_HDR_B,
      GET_ID,
      GET_LEN,
      GET_PAYLOAD,
      GET_SUM,
      GET_FTR_A,
      GET_FTR_B
   } parse_phase_type;

   typedef struct {
      logic [31:0] first_word;
      logic [31:0] second_word;
   } frame_words_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_first_word;
   logic [31:0] rsp_second_word;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'h00;

   // Bytes waiting to be offered, and payload words the recognizer still owes us.
   logic [7:0]      rx_byte_queue[$];
   frame_words_type frame_words_due[$];

   // Shadow copy of the recognizer state and its configuration.
   parse_phase_type parse_phase = HUNT_HDR_A;
   logic [7:0]      shadow_command_id = cfp_pkg::CMD_ID_RESET;
   logic [7:0]      payload_bytes[8];
   logic [3:0]      payload_count = '0;
   logic [7:0]      payload_sum = '0;

   int send_idle_pct = IDLE_PCT;
   int recv_idle_pct = IDLE_PCT;
   int error_count = 0;
   int bytes_accepted = 0;
   int frames_checked = 0;
   int csr_writes = 0;
   int input_stall_cycles = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;

   command_frame_parser_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_word  (rsp_first_word),
      .rsp_second_word (rsp_second_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Packs four payload positions into one word, low byte first. Positions past
   // the payload size read as zero.
   function automatic logic [31:0] pack_payload(input int base);
      logic [31:0] word;
      word = '0;
      for (int k = 0; k < 4; k++) begin
         if (base + k < PAYLOAD_LEN) begin
            word[8*k +: 8] = payload_bytes[base + k];
         end
      end
      return word;
   endfunction

   // Advances the shadow recognizer by one accepted byte and records any frame it completes.
   task automatic advance_recognizer(input logic [7:0] rx);
      frame_words_type words;
      case (parse_phase)
         HUNT_HDR_A: begin
            if (rx == cfp_pkg::HDR_A) parse_phase = HUNT_HDR_B;
         end
         HUNT_HDR_B: parse_phase = (rx == cfp_pkg::HDR_B) ? GET_ID : HUNT_HDR_A;
         GET_ID: parse_phase = (rx == shadow_command_id) ? GET_LEN : HUNT_HDR_A;
         GET_LEN: begin
            if (rx == 8'(PAYLOAD_LEN)) begin
               payload_count = '0;
               payload_sum = '0;
               parse_phase = GET_PAYLOAD;
            end else begin
               parse_phase = HUNT_HDR_A;
            end
         end
         GET_PAYLOAD: begin
            payload_bytes[payload_count[2:0]] = rx;
            payload_sum = payload_sum + rx;
            payload_count = payload_count + 4'd1;
            if (int'(payload_count) >= PAYLOAD_LEN) parse_phase = GET_SUM;
         end
         GET_SUM: parse_phase = (rx == payload_sum) ? GET_FTR_A : HUNT_HDR_A;
         GET_FTR_A: parse_phase = (rx == cfp_pkg::FTR_A) ? GET_FTR_B : HUNT_HDR_A;
         default: begin
            // A bad second footer byte drops the frame silently.
            if (rx == cfp_pkg::FTR_B) begin
               words.first_word = pack_payload(0);
               words.second_word = pack_payload(4);
               frame_words_due.push_back(words);
            end
            parse_phase = HUNT_HDR_A;
         end
      endcase
   endtask

   // Request driver: holds a pending transaction until it is taken, otherwise offers the
   // next queued byte unless it decides to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            advance_recognizer(req_rx_byte);
            bytes_accepted++;
         end
         if (req_valid && !req_ready) begin
            input_stall_cycles++;
         end else if (rx_byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: random back-pressure, plus one long hold-off once traffic is
   // flowing so that the block fills up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && frames_checked >= 12 && rx_byte_queue.size() > 100) begin
         hold_left = HOLD_CYCLES;
         long_hold_done = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Response monitor: every completed transaction is matched against the oldest frame due.
   always @(posedge clock) begin : check_rsp
      frame_words_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_words_due.size() == 0) begin
            $error("unexpected result: first_word %h second_word %h",
                   rsp_first_word, rsp_second_word);
            error_count++;
         end else begin
            want = frame_words_due.pop_front();
            if (rsp_first_word !== want.first_word) begin
               $error("first_word: expected %h, got %h", want.first_word, rsp_first_word);
               error_count++;
            end
            if (rsp_second_word !== want.second_word) begin
               $error("second_word: expected %h, got %h", want.second_word, rsp_second_word);
               error_count++;
            end
            frames_checked++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d frames outstanding.",
                  cycle_count, frame_words_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Picks a payload byte, leaning toward the all-zero and all-one extremes.
   function automatic logic [7:0] pick_payload_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Queues one frame. A negative corrupt_pos leaves it intact; keep_len cuts it short.
   task automatic queue_frame(input logic [7:0] payload[8], input int corrupt_pos,
                              input int keep_len);
      logic [7:0] frame_q[$];
      logic [7:0] sum;
      sum = '0;
      frame_q.push_back(cfp_pkg::HDR_A);
      frame_q.push_back(cfp_pkg::HDR_B);
      frame_q.push_back(shadow_command_id);
      frame_q.push_back(8'(PAYLOAD_LEN));
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         frame_q.push_back(payload[i]);
         sum = sum + payload[i];
      end
      frame_q.push_back(sum);
      frame_q.push_back(cfp_pkg::FTR_A);
      frame_q.push_back(cfp_pkg::FTR_B);
      if (corrupt_pos >= 0) begin
         frame_q[corrupt_pos] = frame_q[corrupt_pos] ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < keep_len; i++) rx_byte_queue.push_back(frame_q[i]);
   endtask

   // Mostly well-formed frames with random payloads; the rest are damaged or cut-off
   // frames and bursts of line noise that favor the delimiter values.
   task automatic queue_random_traffic(input int byte_budget);
      logic [7:0] payload[8];
      int start_size;
      int r;
      int noise_len;
      start_size = rx_byte_queue.size();
      while (rx_byte_queue.size() - start_size < byte_budget) begin
         for (int i = 0; i < 8; i++) payload[i] = pick_payload_byte();
         r = $urandom_range(0, 99);
         if (r < 65) begin
            queue_frame(payload, -1, FRAME_LEN);
         end else if (r < 80) begin
            queue_frame(payload, $urandom_range(0, FRAME_LEN - 1), FRAME_LEN);
         end else if (r < 90) begin
            queue_frame(payload, -1, $urandom_range(1, FRAME_LEN - 1));
         end else begin
            noise_len = $urandom_range(1, 5);
            for (int i = 0; i < noise_len; i++) begin
               case ($urandom_range(0, 9))
                  0: rx_byte_queue.push_back(cfp_pkg::HDR_A);
                  1: rx_byte_queue.push_back(cfp_pkg::HDR_B);
                  2: rx_byte_queue.push_back(cfp_pkg::FTR_A);
                  3: rx_byte_queue.push_back(cfp_pkg::FTR_B);
                  default: rx_byte_queue.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end
      end
   endtask

   // Waits until every queued byte is taken and every frame has come out, then lets
   // any byte still inside the block settle.
   task automatic wait_until_drained();
      do @(posedge clock);
      while (rx_byte_queue.size() > 0 || req_valid || frame_words_due.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the command identifier through the register port; only called while idle.
   task automatic write_command_id(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      shadow_command_id = value;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin : run_test
      logic [7:0] payload[8];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset identifier: one frame with extreme payload
      // values, a doubled first header byte, a wrong length and a wrong identifier.
      payload = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h0A, 8'h0D};
      queue_frame(payload, -1, FRAME_LEN);
      rx_byte_queue.push_back(cfp_pkg::HDR_A);
      rx_byte_queue.push_back(cfp_pkg::HDR_A);
      rx_byte_queue.push_back(cfp_pkg::HDR_B);
      rx_byte_queue.push_back(cfp_pkg::HDR_A);
      rx_byte_queue.push_back(cfp_pkg::HDR_B);
      rx_byte_queue.push_back(cfp_pkg::CMD_ID_RESET);
      rx_byte_queue.push_back(8'(PAYLOAD_LEN - 1));
      rx_byte_queue.push_back(cfp_pkg::HDR_A);
      rx_byte_queue.push_back(cfp_pkg::HDR_B);
      rx_byte_queue.push_back(8'h02);
      queue_random_traffic(150);
      wait_until_drained();

      // Lowest identifier, with neither side idling at all.
      write_command_id(8'h00);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_traffic(200);
      wait_until_drained();
      send_idle_pct = IDLE_PCT;
      recv_idle_pct = IDLE_PCT;

      // Highest identifier; the long receiver hold-off usually lands here.
      write_command_id(8'hFF);
      queue_random_traffic(300);
      wait_until_drained();

      // An identifier equal to the first header byte.
      write_command_id(cfp_pkg::HDR_A);
      queue_random_traffic(200);
      wait_until_drained();

      write_command_id(8'($urandom_range(0, 255)));
      queue_random_traffic(200);
      wait_until_drained();

      $display("Covered %0d bytes, %0d frames checked, %0d identifier writes.",
               bytes_accepted, frames_checked, csr_writes);
      $display("Input was held back for %0d cycles; long output hold-off %s.",
               input_stall_cycles, long_hold_done ? "applied" : "not reached");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
